/* design/kbsv_pkg.sv */
package kbsv_pkg;

  // Build constants
  localparam int NUM_KEYS   = 12;
  localparam int PHASE_BITS = 32;
  localparam int ROM_KEYS   = 12;
  localparam int KEY_LIMIT  = (NUM_KEYS < ROM_KEYS) ? NUM_KEYS : ROM_KEYS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MAX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MIN = CFG_IDX_W'(1);

  // Request opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // Knob transition codes, previous pair over current pair
  localparam logic [3:0] KNOB_UP_A   = 4'h1;
  localparam logic [3:0] KNOB_UP_B   = 4'hE;
  localparam logic [3:0] KNOB_DOWN_A = 4'h4;
  localparam logic [3:0] KNOB_DOWN_B = 4'hB;

  localparam logic [3:0] VOLUME_FULL = 4'd8;
  localparam logic [3:0] VOLUME_RESET_MAX = 4'd8;
  localparam logic [3:0] VOLUME_RESET_MIN = 4'd0;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [3:0]            volume_t;

  typedef struct packed {
    logic        opcode;
    logic [11:0] key_bits;
    logic [1:0]  knob_bits;
  } in_req_t;

  typedef struct packed {
    logic [7:0] sample_value;
    volume_t    volume_level;
  } out_res_t;

  typedef struct packed {
    phase_t     phase;
    phase_t     step;
    volume_t    volume;
    logic [1:0] prev_knob;
  } voice_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

  // Equal-tempered note steps, key 9 is A440 at 22 kHz
  function automatic logic [31:0] note_step(input logic [3:0] idx);
    logic [31:0] s;
    case (idx)
      4'd0:    s = 32'd51076056;
      4'd1:    s = 32'd54113197;
      4'd2:    s = 32'd57330935;
      4'd3:    s = 32'd60740009;
      4'd4:    s = 32'd64351798;
      4'd5:    s = 32'd68178356;
      4'd6:    s = 32'd72232452;
      4'd7:    s = 32'd76527617;
      4'd8:    s = 32'd81078186;
      4'd9:    s = 32'd85899345;
      4'd10:   s = 32'd91007186;
      4'd11:   s = 32'd96418755;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

endpackage

/* design/kbsv_state_mem.sv */
module kbsv_state_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kbsv_pkg::mem_ctrl_t    ctrl,
  input  kbsv_pkg::voice_state_t wr_data,
  output kbsv_pkg::voice_state_t rd_data
);

  kbsv_pkg::voice_state_t state_mem_r [1];
  kbsv_pkg::voice_state_t rd_data_r;
  logic                   vld_r;

  // Entry valid flag: an unwritten entry reads as the reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.wr_en) begin
      vld_r <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      state_mem_r[0] <= wr_data;
    end
  end

  // Registered read, forward a write landing on the same edge
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      if (ctrl.wr_en) begin
        rd_data_r <= wr_data;
      end else if (vld_r) begin
        rd_data_r <= state_mem_r[0];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/kbsv_update.sv */
module kbsv_update (
  input  kbsv_pkg::in_req_t      req,
  input  kbsv_pkg::voice_state_t cur,
  input  kbsv_pkg::volume_t      volume_max,
  input  kbsv_pkg::volume_t      volume_min,
  output kbsv_pkg::voice_state_t nxt,
  output kbsv_pkg::out_res_t     res
);

  logic [3:0]           knob_code;
  logic signed [5:0]    vol_sum;
  kbsv_pkg::volume_t    vol_scan;
  kbsv_pkg::phase_t     step_sel;
  kbsv_pkg::phase_t     phase_sum;
  logic [7:0]           top;
  logic [3:0]           shift;
  logic [7:0]           mag;
  logic [7:0]           sample;

  // Decode the knob and clamp the volume
  always_comb begin
    knob_code = {cur.prev_knob, req.knob_bits};
    vol_sum   = $signed({2'b00, cur.volume});
    if (knob_code == kbsv_pkg::KNOB_UP_A || knob_code == kbsv_pkg::KNOB_UP_B) begin
      vol_sum = vol_sum + 6'sd1;
    end else if (knob_code == kbsv_pkg::KNOB_DOWN_A ||
                 knob_code == kbsv_pkg::KNOB_DOWN_B) begin
      vol_sum = vol_sum - 6'sd1;
    end
    if (vol_sum > $signed({2'b00, volume_max})) begin
      vol_scan = volume_max;
    end else if (vol_sum < $signed({2'b00, volume_min})) begin
      vol_scan = volume_min;
    end else begin
      vol_scan = vol_sum[3:0];
    end
  end

  // Highest pressed key picks the step
  always_comb begin
    step_sel = '0;
    for (int i = 0; i < kbsv_pkg::KEY_LIMIT; i++) begin
      if (!req.key_bits[i]) begin
        step_sel = kbsv_pkg::phase_t'(kbsv_pkg::note_step(4'(i)) >>
                                      (32 - kbsv_pkg::PHASE_BITS));
      end
    end
  end

  // Advance the phase and scale the recentred top byte
  always_comb begin
    phase_sum = cur.phase + cur.step;
    top       = phase_sum[kbsv_pkg::PHASE_BITS-1 -: 8];
    shift     = (cur.volume >= kbsv_pkg::VOLUME_FULL) ? 4'd0
                                                      : kbsv_pkg::VOLUME_FULL - cur.volume;
    if (!top[7]) begin
      mag    = 8'd127 - top;
      sample = 8'd127 - (mag >> shift);
    end else begin
      mag    = top - 8'd128;
      sample = 8'd128 + (mag >> shift);
    end
  end

  // Merge the two kinds of request
  always_comb begin
    nxt = cur;
    res.sample_value = 8'd0;
    if (req.opcode == kbsv_pkg::OP_SCAN) begin
      nxt.volume    = vol_scan;
      nxt.prev_knob = req.knob_bits;
      nxt.step      = step_sel;
    end else begin
      nxt.phase        = phase_sum;
      res.sample_value = sample;
    end
    res.volume_level = nxt.volume;
  end

endmodule

/* design/keyboard_sawtooth_voice_unit.sv */
// A request waits in the request stage for its state read, then its result goes to the
// output register. One request per cycle unless the output stalls; the voice state word
// is read on accept and written back with the result; the write forwards into the read.
// Reset (rst_n low, synchronous): pipeline and output empty, volume limits
// back to 8 and 0, voice state reads as zero until first written.
module keyboard_sawtooth_voice_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  kbsv_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output kbsv_pkg::out_res_t                  out_res,
  input  logic                                cfg_we,
  input  logic [kbsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kbsv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  kbsv_pkg::volume_t      volume_max_r;
  kbsv_pkg::volume_t      volume_min_r;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  kbsv_pkg::in_req_t      s1_req_r;
  logic                   out_valid_r;
  kbsv_pkg::out_res_t     out_res_r;
  logic                   in_accept;
  logic                   out_free;
  logic                   fire;
  kbsv_pkg::mem_ctrl_t    mem_ctrl;
  kbsv_pkg::voice_state_t state_cur;
  kbsv_pkg::voice_state_t state_nxt;
  kbsv_pkg::out_res_t     res_nxt;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign s1_valid_nxt = in_accept || (s1_valid_r && !fire);

  assign mem_ctrl.rd_en = in_accept;
  assign mem_ctrl.wr_en = fire;

  // Volume limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_max_r <= kbsv_pkg::VOLUME_RESET_MAX;
      volume_min_r <= kbsv_pkg::VOLUME_RESET_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        kbsv_pkg::CFG_VOLUME_MAX: volume_max_r <= cfg_wdata;
        kbsv_pkg::CFG_VOLUME_MIN: volume_min_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request stage, waits for the state read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= in_req;
    end
  end

  // Output register, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  kbsv_state_mem u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mem_ctrl),
    .wr_data (state_nxt),
    .rd_data (state_cur)
  );

  kbsv_update u_update (
    .req        (s1_req_r),
    .cur        (state_cur),
    .volume_max (volume_max_r),
    .volume_min (volume_min_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_ITEMS = 185;

  // Spare register indexes, decoded by nothing
  localparam logic [kbsv_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = kbsv_pkg::CFG_IDX_W'(2);
  localparam logic [kbsv_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = kbsv_pkg::CFG_IDX_W'(3);

  // Knob walk directions
  localparam logic TURN_UP   = 1'b1;
  localparam logic TURN_DOWN = 1'b0;

  // Equal-tempered phase increments, key 0 in the lowest word
  localparam logic [11:0][31:0] NOTE_INC = {
    32'd96418755, 32'd91007186, 32'd85899345, 32'd81078186,
    32'd76527617, 32'd72232452, 32'd68178356, 32'd64351798,
    32'd60740009, 32'd57330935, 32'd54113197, 32'd51076056
  };

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  kbsv_pkg::in_req_t               in_req = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  kbsv_pkg::out_res_t              out_res;
  logic                            cfg_we = 1'b0;
  logic [kbsv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kbsv_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Requests waiting to be driven and voice results still owed
  kbsv_pkg::in_req_t  req_queue[$];
  kbsv_pkg::out_res_t results_due[$];
  bit       req_taken = 1'b0;
  int       sender_idle_pct = 0;
  int       stall_pct = 0;
  int       quiet_cycles = 0;
  int       error_count = 0;

  // Voice state and volume limits as the block should hold them
  kbsv_pkg::phase_t phase_acc = '0;
  kbsv_pkg::phase_t note_inc = '0;
  int         vol_level = 0;
  logic [1:0] last_knob = 2'b00;
  int         lim_max = kbsv_pkg::VOLUME_RESET_MAX;
  int         lim_min = kbsv_pkg::VOLUME_RESET_MIN;

  // Stimulus generator's view of the knob
  logic [1:0] knob_pos = 2'b00;
  logic       turn_dir = TURN_UP;

  keyboard_sawtooth_voice_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the voice by one request and return the sample and volume it gives
  function automatic kbsv_pkg::out_res_t predict_voice_result(input kbsv_pkg::in_req_t r);
    kbsv_pkg::out_res_t res;
    logic [3:0] code;
    logic [7:0] top;
    int         v;
    int         sh;
    res = '0;
    if (r.opcode == kbsv_pkg::OP_SCAN) begin
      code = {last_knob, r.knob_bits};
      v = vol_level;
      if (code == kbsv_pkg::KNOB_UP_A || code == kbsv_pkg::KNOB_UP_B) begin
        v = v + 1;
      end else if (code == kbsv_pkg::KNOB_DOWN_A || code == kbsv_pkg::KNOB_DOWN_B) begin
        v = v - 1;
      end
      // upper limit wins when the limits cross
      if (v > lim_max) begin
        v = lim_max;
      end else if (v < lim_min) begin
        v = lim_min;
      end
      vol_level = v & 15;
      last_knob = r.knob_bits;
      // highest pressed key wins
      note_inc = '0;
      for (int i = 0; i < kbsv_pkg::KEY_LIMIT; i++) begin
        if (!r.key_bits[i]) begin
          note_inc = kbsv_pkg::phase_t'(NOTE_INC[i] >> (32 - kbsv_pkg::PHASE_BITS));
        end
      end
    end else begin
      phase_acc = phase_acc + note_inc;
      top = phase_acc[kbsv_pkg::PHASE_BITS-1 -: 8];
      sh = (vol_level >= kbsv_pkg::VOLUME_FULL) ? 0 : 8 - vol_level;
      if (top < 8'd128) begin
        res.sample_value = 8'd127 - ((8'd127 - top) >> sh);
      end else begin
        res.sample_value = 8'd128 + ((top - 8'd128) >> sh);
      end
    end
    res.volume_level = kbsv_pkg::volume_t'(vol_level);
    return res;
  endfunction

  function automatic kbsv_pkg::in_req_t make_req(input logic op, input logic [11:0] keys,
                                                 input logic [1:0] knob);
    kbsv_pkg::in_req_t r;
    r.opcode = op;
    r.key_bits = keys;
    r.knob_bits = knob;
    return r;
  endfunction

  // Next knob position one detent along the quadrature cycle
  function automatic logic [1:0] knob_step(input logic [1:0] pos, input logic dir);
    logic [1:0] nxt;
    case (pos)
      2'd0:    nxt = (dir == TURN_UP) ? 2'd1 : 2'd2;
      2'd1:    nxt = (dir == TURN_UP) ? 2'd3 : 2'd0;
      2'd3:    nxt = (dir == TURN_UP) ? 2'd2 : 2'd1;
      default: nxt = (dir == TURN_UP) ? 2'd0 : 2'd3;
    endcase
    return nxt;
  endfunction

  function automatic logic [11:0] random_keys();
    logic [11:0] k;
    case ($urandom_range(0, 3))
      0:       k = 12'hFFF;
      1:       k = 12'hFFF;
      2:       k = ~(12'h001 << $urandom_range(0, 11));
      default: k = 12'($urandom);
    endcase
    if (k == 12'hFFF && $urandom_range(0, 1) == 0) begin
      k = ~(12'h001 << $urandom_range(0, 11));
    end
    return k;
  endfunction

  task automatic flag_error(input string msg);
    $display("tb_top: mismatch: %s", msg);
    error_count++;
  endtask

  // Write one configuration register while the block is idle
  task automatic write_limit(input logic [kbsv_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= kbsv_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == kbsv_pkg::CFG_VOLUME_MAX) begin
      lim_max = val & 15;
    end else if (idx == kbsv_pkg::CFG_VOLUME_MIN) begin
      lim_min = val & 15;
    end
    quiet_cycles = 0;
  endtask

  // Hold until every queued request is taken and every result has come back
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Drive requests and the result stall on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || req_taken) begin
        if (req_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_req <= req_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    kbsv_pkg::out_res_t due;
    bit       moved;
    moved = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      results_due.push_back(predict_voice_result(in_req));
      req_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (results_due.size() == 0) begin
        flag_error($sformatf("result with none due: sample %0d volume %0d",
                             out_res.sample_value, out_res.volume_level));
      end else begin
        due = results_due.pop_front();
        if (out_res.sample_value !== due.sample_value) begin
          flag_error($sformatf("sample_value got %0d want %0d",
                               out_res.sample_value, due.sample_value));
        end
        if (out_res.volume_level !== due.volume_level) begin
          flag_error($sformatf("volume_level got %0d want %0d",
                               out_res.volume_level, due.volume_level));
        end
      end
    end
    // watchdog on traffic in either direction
    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: timeout after %0d quiet cycles", quiet_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [11:0] keys;
    int          r;
    int          vmax;
    int          vmin;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: all sixteen knob transitions, key extremes, every single key
    req_queue.push_back(make_req(kbsv_pkg::OP_TICK, 12'hFFF, 2'd0));
    for (int j = 0; j < 16; j++) begin
      case (j)
        0:       keys = 12'hFFF;
        1:       keys = 12'h000;
        14:      keys = 12'h555;
        15:      keys = 12'hAAA;
        default: keys = ~(12'h001 << (j - 2));
      endcase
      case (j)
        0, 2, 4, 15:       knob_pos = 2'd0;
        1, 6, 7, 9:        knob_pos = 2'd1;
        3, 8, 11, 12:      knob_pos = 2'd2;
        default:           knob_pos = 2'd3;
      endcase
      req_queue.push_back(make_req(kbsv_pkg::OP_SCAN, keys, knob_pos));
      if (j % 2 == 1) begin
        req_queue.push_back(make_req(kbsv_pkg::OP_TICK, 12'h000, 2'd3));
      end
    end
    wait_drained();

    // Random phases, each under its own limits and idling pattern
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       begin vmax = 8; vmin = 0; end
        1:       begin vmax = 8; vmin = 8; end
        2:       begin vmax = 0; vmin = 0; end
        3:       begin vmax = 5; vmin = 2; end
        4:       begin vmax = 2; vmin = 6; end
        5:       begin vmax = 0; vmin = 8; end
        6:       begin vmax = $urandom_range(0, 8); vmin = $urandom_range(0, 8); end
        default: begin vmax = 8; vmin = 0; end
      endcase
      write_limit(kbsv_pkg::CFG_VOLUME_MAX, vmax);
      if (p == 3 || p == 7) begin
        write_limit(CFG_SPARE_A, $urandom_range(0, 15));
        write_limit(CFG_SPARE_B, $urandom_range(0, 15));
      end
      write_limit(kbsv_pkg::CFG_VOLUME_MIN, vmin);
      case (p % 4)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 63; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 63; end
        default: begin sender_idle_pct = 16; stall_pct = 16; end
      endcase
      // two halves with a full drain between them
      for (int h = 0; h < 2; h++) begin
        for (int n = 0; n < PHASE_ITEMS / 2; n++) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            req_queue.push_back(make_req(kbsv_pkg::OP_TICK, 12'($urandom), 2'($urandom)));
          end else if (r < 88) begin
            // clean detent turn, mostly upwards
            if ($urandom_range(0, 9) == 0) begin
              turn_dir = ($urandom_range(0, 9) < 6) ? TURN_UP : TURN_DOWN;
            end
            knob_pos = knob_step(knob_pos, turn_dir);
            req_queue.push_back(make_req(kbsv_pkg::OP_SCAN, random_keys(), knob_pos));
          end else begin
            knob_pos = 2'($urandom);
            req_queue.push_back(make_req(kbsv_pkg::OP_SCAN, 12'($urandom), knob_pos));
          end
        end
        wait_drained();
      end
    end

    sender_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
